[hw/rtl/tdsm_pkg.sv]
// ----------------------------------------------------------------------------
// Two-digit seven-segment mux package
// Shared types, command codes, segment bit positions and the character
// to segment table used by the display multiplexer.
// ----------------------------------------------------------------------------
package tdsm_pkg;

    // Command codes carried in the mode field of a request.
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_TICK   = 2'd0;
    localparam t_mode MODE_NUMBER = 2'd1;
    localparam t_mode MODE_CHARS  = 2'd2;
    localparam t_mode MODE_BLANK  = 2'd3;

    // Scan phases.
    localparam logic [1:0] PHASE_LEFT  = 2'd0;
    localparam logic [1:0] PHASE_RIGHT = 2'd2;

    // Configuration register indexes (byte address bit 2).
    localparam logic REG_DIGIT_ON  = 1'b0;
    localparam logic REG_BLANK_GAP = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [15:0] DIGIT_ON_RESET  = 16'd5;
    localparam logic [15:0] BLANK_GAP_RESET = 16'd1;

    // Segment bit positions in the output byte.
    localparam logic [7:0] SEG_A = 8'h04;
    localparam logic [7:0] SEG_B = 8'h80;
    localparam logic [7:0] SEG_C = 8'h40;
    localparam logic [7:0] SEG_D = 8'h10;
    localparam logic [7:0] SEG_E = 8'h20;
    localparam logic [7:0] SEG_F = 8'h08;
    localparam logic [7:0] SEG_G = 8'h01;

    localparam logic [7:0] ASCII_ZERO = 8'd48;

    // Reciprocal of 100 scaled by 2^19, rounded down. The estimate it gives
    // is the true quotient or one less for any 16-bit value.
    localparam logic [12:0] DIV100_RECIP = 13'd5242;
    localparam int          DIV100_SHIFT = 19;
    localparam int          QUOT_W       = 10;
    localparam int          PROD_W       = 29;

    // Configuration register values handed to the scan logic.
    typedef struct packed {
        logic [15:0] digit_on_ticks;
        logic [15:0] blank_gap_ticks;
    } t_cfg;

    // Request as it leaves the number split pipeline.
    typedef struct packed {
        logic        valid;
        t_mode       mode;
        logic [7:0]  char_left;
        logic [7:0]  char_right;
        logic [6:0]  rem;
    } t_stage;

    // Character code to segment pattern; unknown codes are blank.
    function automatic logic [7:0] char_segments(input logic [7:0] code);
        logic [7:0] seg;
        seg = 8'h00;
        case (code)
            8'h30: seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;         // '0'
            8'h31: seg = SEG_B | SEG_C;                                         // '1'
            8'h32: seg = SEG_A | SEG_B | SEG_G | SEG_D | SEG_E;                 // '2'
            8'h33: seg = SEG_A | SEG_B | SEG_G | SEG_D | SEG_C;                 // '3'
            8'h34: seg = SEG_B | SEG_C | SEG_F | SEG_G;                         // '4'
            8'h35: seg = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;                 // '5'
            8'h36: seg = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;         // '6'
            8'h37: seg = SEG_A | SEG_B | SEG_C;                                 // '7'
            8'h38: seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G; // '8'
            8'h39: seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;         // '9'
            8'h45: seg = SEG_A | SEG_D | SEG_E | SEG_F | SEG_G;                 // 'E'
            8'h50: seg = SEG_A | SEG_B | SEG_E | SEG_F | SEG_G;                 // 'P'
            8'h41: seg = SEG_A | SEG_B | SEG_C | SEG_E | SEG_F | SEG_G;         // 'A'
            8'h4C: seg = SEG_D | SEG_E | SEG_F;                                 // 'L'
            8'h53: seg = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;                 // 'S'
            8'h6F: seg = SEG_C | SEG_D | SEG_E | SEG_G;                         // 'o'
            8'h72: seg = SEG_E | SEG_G;                                         // 'r'
            8'h75: seg = SEG_C | SEG_D | SEG_E;                                 // 'u'
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    // Decimal digit to segment pattern through the character table.
    function automatic logic [7:0] digit_segments(input logic [3:0] digit);
        return char_segments(ASCII_ZERO + {4'b0000, digit});
    endfunction

endpackage

[hw/rtl/tdsm_if.sv]
// ----------------------------------------------------------------------------
// Two-digit seven-segment mux channels
// Valid/ready channels for command requests and for display results.
// ----------------------------------------------------------------------------
interface tdsm_item_if import tdsm_pkg::*; ();
    logic        valid;
    logic        ready;
    t_mode       mode;
    logic [15:0] number_value;
    logic [7:0]  char_left;
    logic [7:0]  char_right;

    modport source (output valid, mode, number_value, char_left, char_right, input ready);
    modport sink   (input valid, mode, number_value, char_left, char_right, output ready);
endinterface

interface tdsm_result_if ();
    logic       valid;
    logic       ready;
    logic [7:0] segment_byte;
    logic       digit_select;

    modport source (output valid, segment_byte, digit_select, input ready);
    modport sink   (input valid, segment_byte, digit_select, output ready);
endinterface

[hw/rtl/tdsm_apb_regs.sv]
// ----------------------------------------------------------------------------
// Two-digit seven-segment mux register file
// APB-style access to the digit and blank phase durations.
// ----------------------------------------------------------------------------
module tdsm_apb_regs import tdsm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [15:0] r_digit_on;
    logic [15:0] r_blank_gap;
    logic        w_write;

    assign pready  = 1'b1;
    assign w_write = psel & penable & pwrite & pready;

    // Register writes complete in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_on  <= DIGIT_ON_RESET;
            r_blank_gap <= BLANK_GAP_RESET;
        end else if (w_write) begin
            case (paddr[2])
                REG_DIGIT_ON:  r_digit_on  <= pwdata[15:0];
                REG_BLANK_GAP: r_blank_gap <= pwdata[15:0];
                default:       r_digit_on  <= r_digit_on;
            endcase
        end
    end

    // Read data is selected directly from the address.
    always_comb begin
        case (paddr[2])
            REG_DIGIT_ON:  prdata = {16'h0000, r_digit_on};
            REG_BLANK_GAP: prdata = {16'h0000, r_blank_gap};
            default:       prdata = 32'h0000_0000;
        endcase
    end

    assign o_cfg.digit_on_ticks  = r_digit_on;
    assign o_cfg.blank_gap_ticks = r_blank_gap;

endmodule

[hw/rtl/tdsm_num_split.sv]
// ----------------------------------------------------------------------------
// Two-digit seven-segment mux number split
// Input register and two stages that reduce the number modulo 100.
// ----------------------------------------------------------------------------
module tdsm_num_split import tdsm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_valid,
    input  t_mode       i_mode,
    input  logic [15:0] i_number_value,
    input  logic [7:0]  i_char_left,
    input  logic [7:0]  i_char_right,
    output t_stage      o_stage
);

    // Stage 1: input register.
    logic              r_s1_valid;
    t_mode             r_s1_mode;
    logic [15:0]       r_s1_num;
    logic [7:0]        r_s1_cl;
    logic [7:0]        r_s1_cr;

    // Stage 2: quotient estimate.
    logic              r_s2_valid;
    t_mode             r_s2_mode;
    logic [15:0]       r_s2_num;
    logic [7:0]        r_s2_cl;
    logic [7:0]        r_s2_cr;
    logic [QUOT_W-1:0] r_s2_quot;

    // Stage 3: remainder.
    t_stage            r_s3;

    logic [PROD_W-1:0] w_prod;
    logic [QUOT_W-1:0] n_quot;
    logic [16:0]       w_q100;
    logic [16:0]       w_rem_raw;
    logic [7:0]        w_rem8;
    logic [6:0]        n_rem;

    // Quotient estimate by multiplying with the scaled reciprocal.
    always_comb begin
        w_prod = PROD_W'(r_s1_num) * PROD_W'(DIV100_RECIP);
        n_quot = QUOT_W'(w_prod >> DIV100_SHIFT);
    end

    // Remainder with a single correction step.
    always_comb begin
        w_q100    = (17'(r_s2_quot) << 6) + (17'(r_s2_quot) << 5) + (17'(r_s2_quot) << 2);
        w_rem_raw = {1'b0, r_s2_num} - w_q100;
        w_rem8    = w_rem_raw[7:0];
        n_rem     = (w_rem8 >= 8'd100) ? 7'(w_rem8 - 8'd100) : w_rem8[6:0];
    end

    // All stages move together on an advance; reset clears only the valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid      <= i_valid;
            r_s2_valid      <= r_s1_valid;
            r_s3.valid      <= r_s2_valid;
            r_s1_mode       <= i_mode;
            r_s1_num        <= i_number_value;
            r_s1_cl         <= i_char_left;
            r_s1_cr         <= i_char_right;
            r_s2_mode       <= r_s1_mode;
            r_s2_num        <= r_s1_num;
            r_s2_cl         <= r_s1_cl;
            r_s2_cr         <= r_s1_cr;
            r_s2_quot       <= n_quot;
            r_s3.mode       <= r_s2_mode;
            r_s3.char_left  <= r_s2_cl;
            r_s3.char_right <= r_s2_cr;
            r_s3.rem        <= n_rem;
        end
    end

    assign o_stage = r_s3;

`ifndef ASSERT_OFF
    // The corrected remainder always lands in the two-digit range.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3.valid |-> (r_s3.rem < 7'd100))
        else $error("remainder out of range");
`endif

endmodule

[hw/rtl/tdsm_scan.sv]
// ----------------------------------------------------------------------------
// Two-digit seven-segment mux scan logic
// Digit patterns, phase sequencer, tick counter and the result register.
// ----------------------------------------------------------------------------
module tdsm_scan import tdsm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  t_stage     i_stage,
    input  t_cfg       i_cfg,
    output logic       o_valid,
    output logic [7:0] o_segment_byte,
    output logic       o_digit_select
);

    logic [1:0]  r_phase;
    logic [15:0] r_ticks_left;
    logic [7:0]  r_left_seg;
    logic [7:0]  r_right_seg;
    logic        r_out_valid;
    logic [7:0]  r_out_seg;
    logic        r_out_dsel;

    logic [1:0]  n_phase;
    logic [15:0] n_ticks_left;
    logic [7:0]  n_left_seg;
    logic [7:0]  n_right_seg;
    logic [7:0]  n_out_seg;
    logic [3:0]  w_tens;
    logic [6:0]  w_tens_x10;
    logic [3:0]  w_ones;
    logic        w_fire;
    logic        w_tick;

    assign w_fire = i_adv & i_stage.valid;
    assign w_tick = w_fire & (i_stage.mode == MODE_TICK);

    // Split the remainder into tens and ones by threshold compares.
    always_comb begin
        w_tens = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (i_stage.rem >= 7'(k * 10)) begin
                w_tens = 4'(k);
            end
        end
        w_tens_x10 = (7'(w_tens) << 3) + (7'(w_tens) << 1);
        w_ones     = 4'(i_stage.rem - w_tens_x10);
    end

    // Pattern updates from commands.
    always_comb begin
        n_left_seg  = r_left_seg;
        n_right_seg = r_right_seg;
        case (i_stage.mode)
            MODE_NUMBER: begin
                n_right_seg = digit_segments(w_ones);
                n_left_seg  = (w_tens != 4'd0) ? digit_segments(w_tens) : 8'h00;
            end
            MODE_CHARS: begin
                n_left_seg  = char_segments(i_stage.char_left);
                n_right_seg = char_segments(i_stage.char_right);
            end
            MODE_BLANK: begin
                n_left_seg  = 8'h00;
                n_right_seg = 8'h00;
            end
            default: begin
                n_left_seg  = r_left_seg;
                n_right_seg = r_right_seg;
            end
        endcase
    end

    // Phase advance and tick count; a zero duration acts as one tick.
    always_comb begin
        if (r_ticks_left > 16'd1) begin
            n_phase      = r_phase;
            n_ticks_left = r_ticks_left - 16'd1;
        end else begin
            n_phase      = r_phase + 2'd1;
            n_ticks_left = n_phase[0] ? i_cfg.blank_gap_ticks : i_cfg.digit_on_ticks;
        end
        case (n_phase)
            PHASE_LEFT:  n_out_seg = r_left_seg;
            PHASE_RIGHT: n_out_seg = r_right_seg;
            default:     n_out_seg = 8'h00;
        endcase
    end

    // Display state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PHASE_LEFT;
            r_ticks_left <= DIGIT_ON_RESET;
            r_left_seg   <= 8'h00;
            r_right_seg  <= 8'h00;
        end else if (w_tick) begin
            r_phase      <= n_phase;
            r_ticks_left <= n_ticks_left;
        end else if (w_fire) begin
            r_left_seg   <= n_left_seg;
            r_right_seg  <= n_right_seg;
        end
    end

    // Result register; only ticks produce a result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_out_valid <= w_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_out_seg  <= n_out_seg;
            r_out_dsel <= n_phase[1];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_segment_byte = r_out_seg;
    assign o_digit_select = r_out_dsel;

`ifndef ASSERT_OFF
    // The phase only moves on an accepted tick.
    a_phase_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != $past(r_phase)) |-> $past(w_tick))
        else $error("phase changed without a tick");

    // A pending result matches the phase it was produced in.
    a_dsel_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_dsel == r_phase[1]))
        else $error("digit select does not follow phase");

    // Blank phases show no segments.
    a_blank_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_phase[0]) |-> (r_out_seg == 8'h00))
        else $error("segments lit in a blank phase");

    // Commands never produce a result.
    a_cmd_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (i_stage.mode != MODE_TICK)) |=> !r_out_valid)
        else $error("command produced a result");
`endif

endmodule

[hw/rtl/two_digit_seven_segment_mux.sv]
// A tick request passes the input, quotient, remainder and result registers in turn.
// Throughput: one request per cycle; the four-register pipeline advances whenever the
// result register is empty or its result is taken in the same cycle.
// Reset (synchronous, active low) empties the pipeline, selects the left digit phase,
// loads the tick count with the digit duration and blanks both digit patterns.
// ----------------------------------------------------------------------------
// Two-digit seven-segment display multiplexer
// Scans two digits over one segment bus in left, blank, right, blank phases,
// with patterns set from a number, two characters, or a blank command.
// ----------------------------------------------------------------------------
module two_digit_seven_segment_mux import tdsm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tdsm_item_if.sink     i_item,
    tdsm_result_if.source o_result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    t_cfg   w_cfg;
    t_stage w_stage;
    logic   w_adv;
    logic   w_out_valid;

    // The pipeline moves unless a finished result is still waiting.
    assign w_adv        = ~w_out_valid | o_result.ready;
    assign i_item.ready = w_adv;
    assign o_result.valid = w_out_valid;

    tdsm_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tdsm_num_split u_split (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_valid        (i_item.valid),
        .i_mode         (i_item.mode),
        .i_number_value (i_item.number_value),
        .i_char_left    (i_item.char_left),
        .i_char_right   (i_item.char_right),
        .o_stage        (w_stage)
    );

    tdsm_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_stage        (w_stage),
        .i_cfg          (w_cfg),
        .o_valid        (w_out_valid),
        .o_segment_byte (o_result.segment_byte),
        .o_digit_select (o_result.digit_select)
    );

endmodule
